### rtl/cass_pkg.sv
// ----------------------------------------------------------------------------
// cass_pkg
// Shared types and constants of the capture and script step scheduler.
// ----------------------------------------------------------------------------
package cass_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned IntW    = 32;
  localparam int unsigned CntW    = 64;
  localparam int unsigned StepW   = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned MaxSteps = 16;
  localparam int unsigned InDataW = 88;  // 3+48+4+1+32
  localparam int unsigned OutDataW = 120; // 1+4+48+64 = 117, padded

  typedef enum logic [FuncW-1:0] {
    FN_QUERY   = 3'd0,
    FN_CAP     = 3'd1,
    FN_STEP    = 3'd2,
    FN_FAIL    = 3'd3,
    FN_WRITE   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_LOOP     = 2'd1,
    REG_COUNT    = 2'd2
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item fields
    logic do_begin;   // initialize if not started
    logic div_start;  // start overrun division
    logic div_step;   // one division iteration
    logic apply_ovr;  // add quotient
    logic cap_done;
    logic step_adv;
    logic arm_ld;     // arm from table read
    logic fail;
    logic write_ent;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic [FuncW-1:0] func;
  } sts_t;

  function automatic logic [TimeW-1:0] add48(input logic [TimeW-1:0] a,
                                             input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

### rtl/cass_datapath.sv
// ----------------------------------------------------------------------------
// cass_datapath
// Scheduler state, step table, serial overrun divider and result register.
// ----------------------------------------------------------------------------
module cass_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cass_pkg::cmd_t               cmd,
  output cass_pkg::sts_t               sts,
  input  logic [cass_pkg::InDataW-1:0] in_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [31:0]                  cfg_val,
  output logic [cass_pkg::OutDataW-1:0] out_data
);
  import cass_pkg::*;

  localparam int unsigned CtrW = $clog2(TimeW + 1);

  logic [IntW-1:0]   interval_r;
  logic              loop_r;
  logic [CountW-1:0] count_r;

  logic [FuncW-1:0]  func_r;
  logic [TimeW-1:0]  now_r;
  logic [StepW-1:0]  eidx_r;
  logic              edly_r;
  logic [IntW-1:0]   edelay_r;

  logic [TimeW-1:0]  cap_r, stp_r;
  logic [StepW-1:0]  cur_r;
  logic              run_r, started_r;
  logic [CntW-1:0]   skip_r;

  logic [IntW:0]     table_mem [MaxSteps];
  logic [IntW:0]     ent_r;

  // restoring divider: remainder, quotient, count
  logic [TimeW-1:0]  rem_r, quo_r;
  logic [IntW:0]     part_r;
  logic [CtrW-1:0]   dcnt_r;
  logic              busy_r;

  logic [OutDataW-1:0] out_r;

  logic [CountW-1:0] used;
  logic [StepW:0]    cur_inc;
  logic [IntW:0]     trial;
  logic [TimeW-1:0]  arm_val;
  logic [CntW:0]     skip_sum;

  assign used = (count_r > CountW'(MaxSteps)) ? CountW'(MaxSteps) : count_r;
  assign cur_inc = {1'b0, cur_r} + 1'b1;
  assign trial = {part_r[IntW-1:0], rem_r[TimeW-1]} - {1'b0, interval_r};
  assign arm_val = ent_r[IntW] ? add48(now_r, {{(TimeW-IntW){1'b0}}, ent_r[IntW-1:0]})
                               : now_r;
  assign skip_sum = {1'b0, skip_r} + {{(CntW-TimeW+1){1'b0}}, quo_r};

  assign sts.div_busy = busy_r;
  assign sts.func = func_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      loop_r <= 1'b0;
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_INTERVAL: interval_r <= cfg_val;
        REG_LOOP:     loop_r <= cfg_val[0];
        REG_COUNT:    count_r <= cfg_val[CountW-1:0];
        default: ;
      endcase
    end
  end

  // table port: write on entry writes; the current step is read always
  always_ff @(posedge clk) begin
    if (cmd.write_ent)
      table_mem[eidx_r] <= {edly_r, edelay_r};
    ent_r <= table_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_data[2:0];
      now_r    <= in_data[50:3];
      eidx_r   <= in_data[54:51];
      edly_r   <= in_data[55];
      edelay_r <= in_data[87:56];
    end
    if (cmd.out_load) begin
      if (!run_r || cap_r <= stp_r)
        out_r <= {3'b0, skip_r, cap_r, 4'd0, 1'b0};
      else
        out_r <= {3'b0, skip_r, stp_r, cur_r, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
      stp_r <= '0;
      cur_r <= '0;
      run_r <= 1'b0;
      started_r <= 1'b0;
      skip_r <= '0;
      busy_r <= 1'b0;
      dcnt_r <= '0;
      rem_r <= '0;
      quo_r <= '0;
      part_r <= '0;
    end else begin
      if (cmd.do_begin && !started_r) begin
        cap_r <= now_r;
        run_r <= (used != '0);
        cur_r <= cur_r;
        started_r <= 1'b1;
      end
      if (cmd.arm_ld) stp_r <= arm_val;
      if (cmd.div_start) begin
        quo_r <= '0;
        if (interval_r != '0 && now_r > cap_r) begin
          rem_r <= now_r - cap_r;
          part_r <= '0;
          dcnt_r <= CtrW'(TimeW);
          busy_r <= 1'b1;
        end
      end else if (cmd.div_step && busy_r) begin
        if (!trial[IntW]) begin
          part_r <= trial;
          quo_r <= {quo_r[TimeW-2:0], 1'b1};
        end else begin
          part_r <= {part_r[IntW-1:0], rem_r[TimeW-1]};
          quo_r <= {quo_r[TimeW-2:0], 1'b0};
        end
        rem_r <= {rem_r[TimeW-2:0], 1'b0};
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == CtrW'(1)) busy_r <= 1'b0;
      end
      // whole intervals added to the deadline equal now minus the remainder
      if (cmd.apply_ovr && quo_r != '0) begin
        cap_r <= now_r - {{(TimeW-IntW){1'b0}}, part_r[IntW-1:0]};
        skip_r <= skip_sum[CntW] ? {CntW{1'b1}} : skip_sum[CntW-1:0];
      end
      if (cmd.cap_done) cap_r <= add48(now_r, {{(TimeW-IntW){1'b0}}, interval_r});
      if (cmd.step_adv) begin
        if (cur_inc >= {1'b0, used}) begin
          if (!loop_r) begin
            run_r <= 1'b0;
            cur_r <= cur_inc[StepW-1:0];
          end else begin
            cur_r <= '0;
          end
        end else begin
          cur_r <= cur_inc[StepW-1:0];
        end
      end
      if (cmd.fail) run_r <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> dcnt_r != '0) else $error("divider busy with zero count");
  assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> started_r) else $error("script running before start");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply_ovr |-> !busy_r) else $error("quotient applied mid-division");

endmodule

### rtl/cass_ctrl.sv
// ----------------------------------------------------------------------------
// cass_ctrl
// Sequencer: takes one item, steps the datapath through it, holds the result.
// ----------------------------------------------------------------------------
module cass_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output cass_pkg::cmd_t cmd,
  input  cass_pkg::sts_t sts
);
  import cass_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_BEG, S_RD, S_ARM, S_DIVS, S_DIV, S_APPLY, S_OUT,
    S_STEP, S_SRD, S_SARM, S_CAP
  } state_t;

  state_t state_r;
  logic   ovalid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load = in_tvalid;
      S_DEC:   ;
      S_BEG:   cmd.do_begin = 1'b1;
      S_RD:    ;
      S_ARM:   cmd.arm_ld = 1'b1;
      S_DIVS:  cmd.div_start = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_APPLY: cmd.apply_ovr = 1'b1;
      S_OUT:   cmd.out_load = !ovalid_r || out_tready;
      S_STEP:  cmd.step_adv = 1'b1;
      S_SRD:   ;
      S_SARM:  cmd.arm_ld = 1'b1;
      S_CAP:   cmd.cap_done = 1'b1;
      default: ;
    endcase
    if (state_r == S_DEC) begin
      cmd.fail      = (sts.func == FN_FAIL);
      cmd.write_ent = (sts.func == FN_WRITE);
    end
    if (state_r == S_ARM) cmd.cap_done = (sts.func == FN_CAP);
  end

  // started flag and run flag live in the datapath; S_ARM is reached only
  // right after begin, so step 0 is armed there (cur stays 0 until the first
  // step done). A capture done after start goes through S_CAP instead.
  logic began_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      began_r  <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
      else if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) state_r <= S_DEC;
        S_DEC: begin
          if (sts.func == FN_QUERY || sts.func == FN_CAP || sts.func == FN_STEP)
            state_r <= began_r ? ((sts.func == FN_CAP) ? S_CAP :
                                  (sts.func == FN_STEP) ? S_STEP : S_DIVS)
                               : S_BEG;
          else
            state_r <= S_IDLE;
        end
        S_BEG: begin
          began_r <= 1'b1;
          state_r <= S_RD;
        end
        S_RD:  state_r <= S_ARM;
        S_ARM: begin
          if (sts.func == FN_QUERY) state_r <= S_DIVS;
          else if (sts.func == FN_STEP) state_r <= S_STEP;
          else state_r <= S_IDLE;
        end
        S_DIVS:  state_r <= S_DIV;
        S_DIV:   if (!sts.div_busy) state_r <= S_APPLY;
        S_APPLY: state_r <= S_OUT;
        S_OUT:   if (!ovalid_r || out_tready) state_r <= S_IDLE;
        S_STEP:  state_r <= S_SRD;
        S_SRD:   state_r <= S_SARM;
        S_SARM:  state_r <= S_IDLE;
        S_CAP:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> ovalid_r) else $error("result not presented");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BEG) |=> began_r) else $error("start not recorded");

endmodule

### rtl/capture_and_script_step_scheduler.sv
// ----------------------------------------------------------------------------
// capture_and_script_step_scheduler
// Periodic capture and scripted step scheduler, one item at a time.
// ----------------------------------------------------------------------------
// channel | dir | contents
// in_     | in  | tdata: func, now_ms, entry_index, entry_is_delay, entry_delay_ms
// out_    | out | tdata: due_kind, due_step, wake_at_ms, skipped_total
// cfg_    | in  | index 0 interval_ms, 1 loop_enable, 2 step_count
//
// A query runs the 48-step serial overrun divider only when an interval is
// overdue, and the first timed item passes the start states first; other
// items never use the divider. One item is in work at a time.
// Reset (rst_n low, synchronous) clears all control state; the step table
// holds no reset value. A result waiting in the output register stalls the
// next query only at its final stage.
// ----------------------------------------------------------------------------
module capture_and_script_step_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // func[2:0], now_ms[50:3], entry_index[54:51], entry_is_delay[55],
  // entry_delay_ms[87:56]
  input  logic [cass_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // due_kind[0], due_step[4:1], wake_at_ms[52:5], skipped_total[116:53]
  output logic [cass_pkg::OutDataW-1:0]  out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data
);
  import cass_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cass_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .cmd, .sts
  );

  cass_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_data(in_tdata),
    .cfg_we(cfg_valid),
    .cfg_idx(cfg_index),
    .cfg_val(cfg_data),
    .out_data(out_tdata)
  );

endmodule
